// ===== rtl/cst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

  localparam int unsigned NumSemsDef    = 16;
  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned PidBitsDef    = 8;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned StartW  = 15;
  localparam int unsigned TgtW    = 4;
  localparam int unsigned PidInW  = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 16;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [FuncW-1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_OPEN   = 2'd1,
    FUNC_WAIT   = 2'd2,
    FUNC_SIGNAL = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_QFULL     = 3'd2,
    ST_INVALID   = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_EXISTS    = 3'd5,
    ST_TABLEFULL = 3'd6
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic search;   // key match / free slot / queue search
    logic commit;   // update state and form result
  } cst_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/cst_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cst_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output cst_pkg::cst_cmd_t     cmd_o
);
  import cst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_COMMIT, S_OUT} state_e;
  state_e state_q;
  logic   out_valid_q;

  // Accept a new request while the previous result still waits, if idle
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load   = in_valid_i && in_ready_o;
    cmd_o.search = (state_q == S_SEARCH);
    cmd_o.commit = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on commit, drop it once the result transaction completes
      if (cmd_o.commit) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_SEARCH;
        S_SEARCH: state_q <= S_COMMIT;
        S_COMMIT: if (!out_valid_q || out_ready_i) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/cst_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cst_dp #(
  parameter int unsigned NumSems    = cst_pkg::NumSemsDef,
  parameter int unsigned QueueDepth = cst_pkg::QueueDepthDef,
  parameter int unsigned PidBits    = cst_pkg::PidBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  cst_pkg::cst_cmd_t                cmd_i,
  input  wire logic [cst_pkg::InDataW-1:0] in_data_i,
  output logic [cst_pkg::OutDataW-1:0]     out_data_o
);
  import cst_pkg::*;

  localparam int unsigned SemIdxW = (NumSems > 1) ? $clog2(NumSems) : 1;
  localparam int unsigned QIdxW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  // Semaphore table
  logic [NumSems-1:0]               used_q;
  logic [KeyW-1:0]                  key_q   [NumSems];
  logic signed [CountW-1:0]         count_q [NumSems];
  logic [NumSems-1:0][QueueDepth-1:0] wvalid_q;
  logic [PidBits-1:0]               wpid_q  [NumSems][QueueDepth];

  // Request capture
  logic [FuncW-1:0]  func_q;
  logic [KeyW-1:0]   rkey_q;
  logic [StartW-1:0] start_q;
  logic [TgtW-1:0]   tgt_q;
  logic [PidBits-1:0] pid_q;

  // Search results
  logic               hit_q, free_q, tgt_ok_q, qfree_q, qhas_q;
  logic [SemIdxW-1:0] hit_idx_q, free_idx_q, sidx_q;
  logic [QIdxW-1:0]   qfree_idx_q, qhas_idx_q;
  logic signed [CountW-1:0] cnt_q;
  logic [PidBits-1:0] wpid_rd_q;

  logic [OutDataW-1:0] out_q;
  assign out_data_o = out_q;

  // Combinational searches over the captured request
  logic               hit_d, free_d, qfree_d, qhas_d, tgt_ok_d;
  logic [SemIdxW-1:0] hit_idx_d, free_idx_d, sidx_d;
  logic [QIdxW-1:0]   qfree_idx_d, qhas_idx_d;

  always_comb begin
    hit_d = 1'b0; hit_idx_d = '0; free_d = 1'b0; free_idx_d = '0;
    for (int i = NumSems - 1; i >= 0; i--) begin
      if (used_q[i] && key_q[i] == rkey_q) begin
        hit_d = 1'b1; hit_idx_d = SemIdxW'(i);
      end
      if (!used_q[i]) begin
        free_d = 1'b1; free_idx_d = SemIdxW'(i);
      end
    end
    sidx_d   = SemIdxW'(tgt_q);
    tgt_ok_d = (32'(tgt_q) < NumSems) && used_q[sidx_d];
    qfree_d = 1'b0; qfree_idx_d = '0; qhas_d = 1'b0; qhas_idx_d = '0;
    for (int q = QueueDepth - 1; q >= 0; q--) begin
      if (!wvalid_q[sidx_d][q]) begin
        qfree_d = 1'b1; qfree_idx_d = QIdxW'(q);
      end else begin
        qhas_d = 1'b1; qhas_idx_d = QIdxW'(q);
      end
    end
  end

  // Capture request and search outcome
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_data_i[1:0];
      rkey_q  <= in_data_i[33:2];
      start_q <= in_data_i[48:34];
      tgt_q   <= in_data_i[52:49];
      pid_q   <= PidBits'(in_data_i[60:53]);
    end
    if (cmd_i.search) begin
      hit_q <= hit_d; hit_idx_q <= hit_idx_d;
      free_q <= free_d; free_idx_q <= free_idx_d;
      tgt_ok_q <= tgt_ok_d; sidx_q <= sidx_d;
      qfree_q <= qfree_d; qfree_idx_q <= qfree_idx_d;
      qhas_q <= qhas_d; qhas_idx_q <= qhas_idx_d;
      cnt_q <= count_q[sidx_d];
      wpid_rd_q <= wpid_q[sidx_d][qhas_idx_d];
    end
  end

  // Commit: update table and form the result
  logic signed [CountW-1:0] dec, inc;
  assign dec = (cnt_q != {1'b1, {(CountW-1){1'b0}}}) ? cnt_q - 1'b1 : cnt_q;
  assign inc = (cnt_q != {1'b0, {(CountW-1){1'b1}}}) ? cnt_q + 1'b1 : cnt_q;

  // Form the result fields from the search outcome
  logic [StatusW-1:0] st_d;
  logic [TgtW-1:0]    ridx_d;
  logic               wv_d;
  logic               pid_we;

  always_comb begin
    st_d = ST_OK; ridx_d = '0; wv_d = 1'b0;
    unique case (func_e'(func_q))
      FUNC_CREATE: begin
        if (hit_q) st_d = ST_EXISTS;
        else if (!free_q) st_d = ST_TABLEFULL;
        else ridx_d = TgtW'(free_idx_q);
      end
      FUNC_OPEN: begin
        if (hit_q) ridx_d = TgtW'(hit_idx_q);
        else st_d = ST_NOTFOUND;
      end
      FUNC_WAIT: begin
        if (!tgt_ok_q) st_d = ST_INVALID;
        else begin
          ridx_d = tgt_q;
          if (!dec[CountW-1]) st_d = ST_OK;
          else if (qfree_q) st_d = ST_BLOCKED;
          else st_d = ST_QFULL;
        end
      end
      FUNC_SIGNAL: begin
        if (!tgt_ok_q) st_d = ST_INVALID;
        else begin
          ridx_d = tgt_q;
          wv_d   = qhas_q;
        end
      end
      default: st_d = ST_OK;
    endcase
  end

  assign pid_we = cmd_i.commit && (func_e'(func_q) == FUNC_WAIT) && tgt_ok_q &&
                  dec[CountW-1] && qfree_q;

  // Store the pid of a blocked caller
  always_ff @(posedge clk_i) begin
    if (pid_we) wpid_q[sidx_q][qfree_idx_q] <= pid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      wvalid_q <= '0;
      out_q    <= '0;
      for (int i = 0; i < NumSems; i++) begin
        key_q[i]   <= '0;
        count_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      out_q <= {8'(wv_d ? wpid_rd_q : {PidBits{1'b0}}), wv_d, ridx_d, st_d};
      unique case (func_e'(func_q))
        FUNC_CREATE: begin
          if (!hit_q && free_q) begin
            used_q[free_idx_q]   <= 1'b1;
            key_q[free_idx_q]    <= rkey_q;
            count_q[free_idx_q]  <= CountW'(start_q);
            wvalid_q[free_idx_q] <= '0;
          end
        end
        FUNC_OPEN: begin
        end
        FUNC_WAIT: begin
          if (tgt_ok_q) begin
            count_q[sidx_q] <= dec;
            if (dec[CountW-1] && qfree_q) wvalid_q[sidx_q][qfree_idx_q] <= 1'b1;
          end
        end
        FUNC_SIGNAL: begin
          if (tgt_ok_q) begin
            count_q[sidx_q] <= inc;
            if (qhas_q) wvalid_q[sidx_q][qhas_idx_q] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/counting_semaphore_table_core.sv =====
// An accepted request passes the search and commit states before m_axis_tvalid rises.
// A new request is accepted only once the previous one has committed;
// commit holds while a previous result is still not taken.
// The result register lets a new request enter while the previous result waits.
// Reset (rst_ni low, asynchronous) clears all slots, counts and blocked lists.
`timescale 1ns / 1ps
`default_nettype none
module counting_semaphore_table_core #(
  parameter int unsigned NumSems    = cst_pkg::NumSemsDef,
  parameter int unsigned QueueDepth = cst_pkg::QueueDepthDef,
  parameter int unsigned PidBits    = cst_pkg::PidBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // func[1:0], name_key[33:2], start_value[48:34], target_index[52:49], caller_pid[60:53]
  input  wire logic [cst_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // status[2:0], result_index[6:3], woken_valid[7], woken_pid[15:8]
  output logic [cst_pkg::OutDataW-1:0]      m_axis_tdata
);
  import cst_pkg::*;

  cst_cmd_t cmd;

  cst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  cst_dp #(.NumSems(NumSems), .QueueDepth(QueueDepth), .PidBits(PidBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata),
    .out_data_o(m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_search_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.search) else $error("search did not follow load");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.search |-> !s_axis_tready) else $error("ready while searching");
  a_commit_raises_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid) else $error("commit without result");
`endif
endmodule
`default_nettype wire
